// ===== hw/rtl/lbgc_pkg.sv =====
// shared types and constants for the byte gamma cipher
package lbgc_pkg;

  localparam int BYTE_W         = 8;
  localparam int KEY_W          = 64;
  localparam int LEN_W          = 4;
  localparam int TAP_W          = 8;
  localparam int STEPS_PER_BYTE = 8;
  localparam int CFG_INDEX_W    = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KEY_BYTES  = 2'd0,
    CFG_KEY_LENGTH = 2'd1,
    CFG_TAP_MASK   = 2'd2
  } cfg_index_t;

  localparam logic [KEY_W-1:0] KEY_BYTES_RESET  = '0;
  localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 4'd8;
  localparam logic [TAP_W-1:0] TAP_MASK_RESET   = 8'd5;

  typedef struct packed {
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_length;
    logic [TAP_W-1:0] tap_mask;
  } cfg_t;

endpackage

// ===== hw/rtl/lbgc_cfg_regs.sv =====
// configuration registers with their reset values
module lbgc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lbgc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lbgc_pkg::KEY_W-1:0]         cfg_data,
  output lbgc_pkg::cfg_t                     cfg
);

  lbgc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.key_bytes  <= lbgc_pkg::KEY_BYTES_RESET;
      regs.key_length <= lbgc_pkg::KEY_LENGTH_RESET;
      regs.tap_mask   <= lbgc_pkg::TAP_MASK_RESET;
    end else if (cfg_write) begin
      case (lbgc_pkg::cfg_index_t'(cfg_index))
        lbgc_pkg::CFG_KEY_BYTES: begin
          regs.key_bytes <= cfg_data;
        end
        lbgc_pkg::CFG_KEY_LENGTH: begin
          regs.key_length <= cfg_data[lbgc_pkg::LEN_W-1:0];
        end
        lbgc_pkg::CFG_TAP_MASK: begin
          regs.tap_mask <= cfg_data[lbgc_pkg::TAP_W-1:0];
        end
        default: begin
          regs <= regs;
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hw/rtl/lbgc_keystream.sv =====
// eight unrolled register steps: next register contents and gamma byte
module lbgc_keystream #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  lbgc_pkg::cfg_t                                    cfg,
  input  logic                                              reload,
  input  logic [MAX_KEY_BYTES-1:0][lbgc_pkg::BYTE_W-1:0]    state_cur,
  output logic [MAX_KEY_BYTES-1:0][lbgc_pkg::BYTE_W-1:0]    state_next,
  output logic [lbgc_pkg::BYTE_W-1:0]                       gamma
);

  localparam int IDX_W = $clog2(MAX_KEY_BYTES);
  localparam int STEPS = lbgc_pkg::STEPS_PER_BYTE;

  logic [IDX_W-1:0] last;
  logic [MAX_KEY_BYTES-1:0][lbgc_pkg::BYTE_W-1:0] st [0:STEPS];
  logic [lbgc_pkg::BYTE_W-1:0] fb [0:STEPS-1];

  // effective length: zero acts as one, clipped to the register depth
  always_comb begin
    if (cfg.key_length == '0) begin
      last = '0;
    end else if (cfg.key_length > lbgc_pkg::LEN_W'(MAX_KEY_BYTES)) begin
      last = IDX_W'(MAX_KEY_BYTES - 1);
    end else begin
      last = IDX_W'(cfg.key_length - lbgc_pkg::LEN_W'(1));
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      st[0][i] = reload ? cfg.key_bytes[lbgc_pkg::BYTE_W*i +: lbgc_pkg::BYTE_W]
                        : state_cur[i];
    end
    gamma = '0;
    for (int k = 0; k < STEPS; k++) begin
      fb[k] = '0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        if (cfg.tap_mask[i] && (IDX_W'(i) <= last)) begin
          fb[k] = fb[k] ^ st[k][i];
        end
      end
      gamma = gamma | st[k][last];
      st[k+1][0] = fb[k];
      for (int i = 1; i < MAX_KEY_BYTES; i++) begin
        // positions past the length hold their value
        st[k+1][i] = (IDX_W'(i) <= last) ? st[k][i-1] : st[k][i];
      end
    end
    state_next = st[STEPS];
  end

endmodule

// ===== hw/rtl/lfsr_byte_gamma_cipher.sv =====
// top level of the byte gamma cipher
//
// input channel: in_valid / in_stall carry data_byte and message_start;
// a beat is taken at a rising edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carry cipher_byte, one result
// beat per input beat, in order.
// configuration: cfg_write with cfg_index and cfg_data writes one
// register (key bytes, key length, tap mask); unknown indexes are dropped.
// path: a taken beat goes into the input register, its result into the output register.
// throughput: one byte per cycle while the output is not stalled; the eight register steps of a byte are
// unrolled into xor and mux logic feeding the state register, so the
// state loop closes through combinational logic alone.
// message_start reloads the register from the key before that byte.
// reset: the register goes to all zeros, config to its defaults, both
// pipeline stages empty.
// stall: a held output keeps its beat, the input stage keeps its beat
// and in_stall rises once both stages are full.
module lfsr_byte_gamma_cipher #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [lbgc_pkg::BYTE_W-1:0]            data_byte,
  input  logic                                   message_start,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [lbgc_pkg::BYTE_W-1:0]            cipher_byte,
  input  logic                                   cfg_write,
  input  logic [lbgc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [lbgc_pkg::KEY_W-1:0]             cfg_data
);

  lbgc_pkg::cfg_t cfg;

  logic                                          in_reg_valid;
  logic [lbgc_pkg::BYTE_W-1:0]                   in_reg_data;
  logic                                          in_reg_start;
  logic                                          out_reg_valid;
  logic [lbgc_pkg::BYTE_W-1:0]                   out_reg_data;
  logic [MAX_KEY_BYTES-1:0][lbgc_pkg::BYTE_W-1:0] shift_reg;
  logic [MAX_KEY_BYTES-1:0][lbgc_pkg::BYTE_W-1:0] shift_reg_next;
  logic [lbgc_pkg::BYTE_W-1:0]                   gamma;
  logic                                          out_open;
  logic                                          advance;
  logic                                          in_take;

  lbgc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbgc_keystream #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_keystream (
    .cfg        (cfg),
    .reload     (in_reg_start),
    .state_cur  (shift_reg),
    .state_next (shift_reg_next),
    .gamma      (gamma)
  );

  assign out_open = !out_reg_valid || !out_stall;
  assign advance  = in_reg_valid && out_open;
  assign in_stall = in_reg_valid && !out_open;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid  <= 1'b0;
      out_reg_valid <= 1'b0;
      shift_reg     <= '0;
    end else begin
      if (!in_reg_valid || out_open) begin
        in_reg_valid <= in_take;
      end
      if (out_open) begin
        out_reg_valid <= in_reg_valid;
      end
      if (advance) begin
        shift_reg <= shift_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg_data  <= data_byte;
      in_reg_start <= message_start;
    end
    if (advance) begin
      out_reg_data <= in_reg_data ^ gamma;
    end
  end

  assign out_valid   = out_reg_valid;
  assign cipher_byte = out_reg_data;

endmodule

// ===== verif/tb_lfsr_byte_gamma_cipher.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the byte gamma cipher with an in-bench keystream predictor
module tb_lfsr_byte_gamma_cipher;

  localparam int LANES       = 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASES      = 10;
  localparam int PHASE_BYTES = 83;
  // index past the end of the register list, must be dropped
  localparam logic [lbgc_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  class gamma_scoreboard;
    logic [lbgc_pkg::KEY_W-1:0]  key_bytes;
    logic [lbgc_pkg::LEN_W-1:0]  key_length;
    logic [lbgc_pkg::TAP_W-1:0]  tap_mask;
    logic [lbgc_pkg::BYTE_W-1:0] lane [LANES];
    logic [lbgc_pkg::BYTE_W-1:0] cipher_q [$];
    int errors;
    int checked;

    function new();
      key_bytes  = lbgc_pkg::KEY_BYTES_RESET;
      key_length = lbgc_pkg::KEY_LENGTH_RESET;
      tap_mask   = lbgc_pkg::TAP_MASK_RESET;
      foreach (lane[i]) lane[i] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void write_reg(logic [lbgc_pkg::CFG_INDEX_W-1:0] idx,
                            logic [lbgc_pkg::KEY_W-1:0] value);
      case (idx)
        lbgc_pkg::CFG_KEY_BYTES:  key_bytes  = value;
        lbgc_pkg::CFG_KEY_LENGTH: key_length = value[lbgc_pkg::LEN_W-1:0];
        lbgc_pkg::CFG_TAP_MASK:   tap_mask   = value[lbgc_pkg::TAP_W-1:0];
        default: ;
      endcase
    endfunction

    // eight register steps per byte, gamma is the or of the step outputs
    function void note_byte(logic [lbgc_pkg::BYTE_W-1:0] data, logic start);
      int n;
      logic [lbgc_pkg::BYTE_W-1:0] gamma;
      logic [lbgc_pkg::BYTE_W-1:0] fb;
      n = (key_length == 0) ? 1 : ((key_length > LANES) ? LANES : int'(key_length));
      if (start)
        for (int i = 0; i < LANES; i++) lane[i] = key_bytes[8*i +: 8];
      gamma = '0;
      for (int s = 0; s < lbgc_pkg::STEPS_PER_BYTE; s++) begin
        fb = '0;
        for (int i = 0; i < n; i++)
          if (tap_mask[i]) fb ^= lane[i];
        gamma |= lane[n-1];
        for (int i = n - 1; i > 0; i--) lane[i] = lane[i-1];
        lane[0] = fb;
      end
      cipher_q.push_back(data ^ gamma);
    endfunction

    task check_cipher(logic [lbgc_pkg::BYTE_W-1:0] got);
      logic [lbgc_pkg::BYTE_W-1:0] want;
      if (cipher_q.size() == 0) begin
        report($sformatf("cipher_byte %02h with nothing expected", got));
        return;
      end
      want = cipher_q.pop_front();
      checked++;
      if (got !== want)
        report($sformatf("cipher_byte %02h, expected %02h (result %0d)", got, want, checked));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [lbgc_pkg::BYTE_W-1:0]      data_byte = '0;
  logic                             message_start = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [lbgc_pkg::BYTE_W-1:0]      cipher_byte;
  logic                             cfg_write = 1'b0;
  logic [lbgc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lbgc_pkg::KEY_W-1:0]       cfg_data = '0;

  gamma_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  int sent = 0;
  int settings = 0;

  lfsr_byte_gamma_cipher #(.MAX_KEY_BYTES(LANES)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .message_start(message_start),
    .out_valid(out_valid), .out_stall(out_stall), .cipher_byte(cipher_byte),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [lbgc_pkg::BYTE_W-1:0] d, input logic s);
    in_valid      <= 1'b1;
    data_byte     <= d;
    message_start <= s;
    do @(posedge clk); while (in_stall);
    sb.note_byte(d, s);
    sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // hold the input until every expected beat is out, plus pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.cipher_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // upper bits of length and tap words carry garbage to check masking
  task automatic program_regs(input logic [lbgc_pkg::KEY_W-1:0] key,
                              input logic [lbgc_pkg::LEN_W-1:0] len,
                              input logic [lbgc_pkg::TAP_W-1:0] taps);
    logic [lbgc_pkg::CFG_INDEX_W-1:0] idx [4];
    logic [lbgc_pkg::KEY_W-1:0]       val [4];
    idx = '{lbgc_pkg::CFG_KEY_BYTES, lbgc_pkg::CFG_KEY_LENGTH, lbgc_pkg::CFG_TAP_MASK,
            CFG_SPARE};
    val[0] = key;
    val[1] = {{$urandom, $urandom}} & ~64'hF | 64'(len);
    val[2] = {{$urandom, $urandom}} & ~64'hFF | 64'(taps);
    val[3] = {$urandom, $urandom};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_write <= 1'b0;
    settings++;
  endtask

  // result side: checks beats, random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_cipher(cipher_byte);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall  <= 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results pending",
             IDLE_LIMIT, sb.cipher_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [lbgc_pkg::KEY_W-1:0] dir_key [6];
    logic [lbgc_pkg::LEN_W-1:0] dir_len [6];
    logic [lbgc_pkg::TAP_W-1:0] dir_tap [6];
    logic [lbgc_pkg::KEY_W-1:0] key;
    logic [lbgc_pkg::LEN_W-1:0] len;
    logic [lbgc_pkg::TAP_W-1:0] taps;

    dir_key = '{64'h0123_4567_89AB_CDEF, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, '1, '0};
    // full length, length one, zero length, oversize length, taps only above length, length two
    dir_len = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2};
    dir_tap = '{8'hFF, 8'h01, 8'hFE, 8'h80, 8'hF8, 8'h03};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register and reset key are all zeros, so bytes pass through, also after the reload
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    drain();

    for (int d = 0; d < 6; d++) begin
      program_regs(dir_key[d], dir_len[d], dir_tap[d]);
      sender_gap();
      send_byte(8'h00, 1'b1);
      sender_gap();
      send_byte(8'hFF, 1'b0);
      send_byte(lbgc_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
      drain();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       key = '0;
        1:       key = '1;
        default: key = {$urandom, $urandom};
      endcase
      len  = lbgc_pkg::LEN_W'($urandom_range(0, 15));
      taps = lbgc_pkg::TAP_W'($urandom_range(0, 255));
      if (ph == 0) begin
        len  = 4'd8;
        taps = 8'hFF;
      end else if (ph == 1) begin
        len  = 4'd1;
        taps = 8'h00;
      end else if (ph == PHASES - 1) begin
        len = 4'd8;
      end
      calm = (ph == PHASES - 1);
      program_regs(key, len, taps);
      for (int k = 0; k < PHASE_BYTES; k++) begin
        // long output hold-off while bytes keep coming back to back
        if (ph == 3 && k == 10) hold_off_req = 1'b1;
        if (ph == 6 && k == 40) drain();
        if (!(ph == 3 && k >= 10 && k < 40)) sender_gap();
        // mostly proper messages, now and then a missing or extra reload
        send_byte(lbgc_pkg::BYTE_W'($urandom_range(0, 255)),
                  (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0));
      end
      drain();
    end

    $display("%0d bytes sent over %0d key/length/tap settings, %0d results checked",
             sent, settings, sb.checked);
    $display("lengths 0..15, tap extremes, mid-message reloads, long hold-off and full drain");
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
